// File: src/apsg_pkg.sv
package apsg_pkg;

    localparam int DEF_MAX_SIDES     = 64;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int RESULT_CAP        = 64;
    localparam int ANG_W             = 20;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // one prepared arc, passed from front to back
    typedef struct packed {
        logic signed [15:0]      cx;
        logic signed [15:0]      cy;
        logic [14:0]             r;
        logic [6:0]              n;
        logic signed [ANG_W-1:0] start;
        logic signed [ANG_W-1:0] stop;
        logic [16:0]             q0;
        logic [7:0]              r0;
    } arc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // arctan of 2^-i in units of 2^32 per turn
    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

// File: src/apsg_front.sv
module apsg_front
    import apsg_pkg::*;
#(
    parameter int MAX_SIDES = DEF_MAX_SIDES
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [75:0] in_data,
    input  q_stat_t     q_stat,
    output logic        push,
    output arc_t        push_arc
);

    localparam int LIM = (MAX_SIDES < RESULT_CAP) ? MAX_SIDES : RESULT_CAP;

    typedef enum logic [2:0] {IDLE, MULT, SUM, DIV, LOAD, PUSH} state_t;

    state_t state_reg;
    arc_t arc_reg;
    logic signed [10:0] sdeg_reg, edeg_reg;
    logic [11:0] spos, epos;
    logic [27:0] sprod_reg, eprod_reg;
    logic [4:0] div_cnt_reg;
    logic [7:0] rem_reg;
    logic [16:0] quo_reg;
    logic [6:0] n_raw, n_clamp;
    logic [7:0] rem_sh;
    logic [19:0] sbau, ebau;

    // offset by three turns so the conversion stays non-negative
    assign spos = 12'(13'(signed'(sdeg_reg)) + 13'sd1080);
    assign epos = 12'(13'(signed'(edeg_reg)) + 13'sd1080);

    // round(deg * 65536 / 360): pos*182 + floor((pos*4 + 45) / 90) - 3 turns
    assign sbau = 20'({8'd0, spos} * 20'd182 + 20'(sprod_reg[27:20]) - 20'd196608);
    assign ebau = 20'({8'd0, epos} * 20'd182 + 20'(eprod_reg[27:20]) - 20'd196608);

    // side count clamp
    assign n_raw = in_data[53:47];
    always_comb
    begin
        n_clamp = n_raw;
        if (n_raw == 7'd0)
            n_clamp = 7'd1;
        else if (int'(n_raw) > LIM)
            n_clamp = 7'(LIM);
    end

    // restoring step for 65536 / n
    assign rem_sh = {rem_reg[6:0], (div_cnt_reg == 5'd16)};

    assign in_ready = (state_reg == IDLE);
    assign push     = (state_reg == PUSH) && !q_stat.full;
    assign push_arc = arc_reg;

    // sequencer and prepared fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        arc_reg.cx <= in_data[15:0];
                        arc_reg.cy <= in_data[31:16];
                        arc_reg.r  <= in_data[46:32];
                        arc_reg.n  <= n_clamp;
                        sdeg_reg   <= in_data[64:54];
                        edeg_reg   <= in_data[75:65];
                        state_reg  <= MULT;
                    end
                end
                MULT:
                begin
                    sprod_reg <= 28'({2'd0, spos, 2'd0} + 16'd45) * 28'd11651;
                    eprod_reg <= 28'({2'd0, epos, 2'd0} + 16'd45) * 28'd11651;
                    state_reg <= SUM;
                end
                SUM:
                begin
                    arc_reg.start <= signed'(sbau);
                    arc_reg.stop  <= signed'(ebau);
                    rem_reg       <= 8'd0;
                    quo_reg       <= 17'd0;
                    div_cnt_reg   <= 5'd16;
                    state_reg     <= DIV;
                end
                DIV:
                begin
                    if (rem_sh >= {1'b0, arc_reg.n})
                    begin
                        rem_reg <= rem_sh - {1'b0, arc_reg.n};
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    if (div_cnt_reg == 5'd0)
                        state_reg <= LOAD;
                    else
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                // step size into the prepared arc before it is offered
                LOAD:
                begin
                    arc_reg.q0 <= quo_reg;
                    arc_reg.r0 <= {rem_reg[6:0], 1'b0};
                    state_reg  <= PUSH;
                end
                PUSH:
                begin
                    if (!q_stat.full)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// File: src/apsg_queue.sv
module apsg_queue
    import apsg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  arc_t    push_arc,
    input  logic    pop,
    output arc_t    head,
    output q_stat_t stat
);

    arc_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

    // two-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= push_arc;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: src/apsg_back.sv
module apsg_back
    import apsg_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)(
    input  logic        clk,
    input  logic        rst_n,
    input  arc_t        head,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [71:0] out_data,
    output logic        out_last
);

    localparam int IW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    typedef enum logic [2:0] {IDLE, INIT, ROT, MUL, SUM, EMIT} state_t;

    state_t state_reg;
    arc_t arc_reg;
    logic [16:0] q_reg, q_next;
    logic [7:0] rem_reg, rem_next;
    logic [8:0] rem_sum;
    logic [6:0] j_reg;
    logic first_reg, flip_reg;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic signed [31:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [IW-1:0] i_reg;
    logic signed [47:0] px_reg, py_reg;
    logic signed [47:0] rx, ry;
    logic signed [16:0] vx, vy;
    logic signed [16:0] bx_reg, by_reg, ex_reg, ey_reg;
    logic signed [31:0] dx, dy;
    logic signed [32:0] at;
    logic [15:0] b16;
    logic flip_c, last_c, slot_free;
    logic out_valid_reg, out_last_reg;
    logic [71:0] out_data_reg;

    // next vertex angle: quotient and remainder of j*65536/n kept incrementally
    always_comb
    begin
        rem_sum  = {1'b0, rem_reg} + {1'b0, arc_reg.r0};
        q_next   = q_reg + arc_reg.q0;
        rem_next = rem_sum[7:0];
        if (rem_sum >= {1'b0, arc_reg.n, 1'b0})
        begin
            rem_next = 8'(rem_sum - {1'b0, arc_reg.n, 1'b0});
            q_next   = q_reg + arc_reg.q0 + 17'd1;
        end
        ang_next = arc_reg.start + signed'({3'd0, q_next});
    end

    // fold the angle into [-90, 90) degrees
    assign b16    = ang_reg[15:0];
    assign flip_c = b16[15] ^ b16[14];

    // one cordic micro-rotation
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = signed'({3'd0, atan_lut(5'(i_reg))});

    // round product back to coordinate scale and add the centre
    assign rx = px_reg + 48'sd536870912;
    assign ry = py_reg + 48'sd536870912;
    assign vx = 17'(rx >>> 30) + 17'(arc_reg.cx);
    assign vy = 17'(ry >>> 30) + 17'(arc_reg.cy);

    assign last_c    = (ang_reg >= arc_reg.stop) || (j_reg == arc_reg.n);
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (state_reg == IDLE) && !q_stat.empty;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // vertex sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != EMIT))
                out_valid_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        arc_reg   <= head;
                        ang_reg   <= head.start;
                        q_reg     <= 17'd0;
                        rem_reg   <= {1'b0, head.n};
                        j_reg     <= 7'd0;
                        first_reg <= 1'b1;
                        state_reg <= INIT;
                    end
                end
                INIT:
                begin
                    flip_reg  <= flip_c;
                    x_reg     <= CORDIC_GAIN;
                    y_reg     <= 32'sd0;
                    z_reg     <= signed'({b16[15] ^ flip_c, b16[15] ^ flip_c,
                                          b16[14:0], 16'd0});
                    i_reg     <= '0;
                    state_reg <= ROT;
                end
                ROT:
                begin
                    if (!z_reg[32])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    if (int'(i_reg) == CORDIC_STAGES - 1)
                        state_reg <= MUL;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                MUL:
                begin
                    px_reg <= signed'({1'b0, arc_reg.r})
                              * (flip_reg ? -x_reg : x_reg);
                    py_reg <= signed'({1'b0, arc_reg.r})
                              * (flip_reg ? -y_reg : y_reg);
                    state_reg <= SUM;
                end
                SUM:
                begin
                    if (first_reg)
                    begin
                        bx_reg    <= vx;
                        by_reg    <= vy;
                        first_reg <= 1'b0;
                        q_reg     <= q_next;
                        rem_reg   <= rem_next;
                        ang_reg   <= ang_next;
                        j_reg     <= j_reg + 7'd1;
                        state_reg <= INIT;
                    end
                    else
                    begin
                        ex_reg    <= vx;
                        ey_reg    <= vy;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= last_c;
                        out_data_reg  <= {4'd0, ey_reg, ex_reg, by_reg, bx_reg};
                        if (last_c)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            bx_reg    <= ex_reg;
                            by_reg    <= ey_reg;
                            q_reg     <= q_next;
                            rem_reg   <= rem_next;
                            ang_reg   <= ang_next;
                            j_reg     <= j_reg + 7'd1;
                            state_reg <= INIT;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// File: src/arc_polygon_segment_generator_top.sv
// Arc polygon segment generator. Each request on the slave side describes an
// arc (centre, radius, side count, start and end angle in whole degrees); the
// block returns one line segment per polygon step on the master side, the
// final one with tlast set. Sides of 0 count as 1 and larger counts clamp to
// MAX_SIDES (never above 64). A front section converts the angles and works
// out the step size with a serial restoring divider, and hands the arc
// through a two-entry queue to the back section, which runs a single
// iterative CORDIC: each vertex passes through INIT, the ROT iterations, MUL
// and SUM, and an arc stops early when the end angle is reached. The front
// takes the next request while the back is still busy, and a finished
// segment waits in an output register.
module arc_polygon_segment_generator_top
    import apsg_pkg::*;
#(
    parameter int MAX_SIDES     = DEF_MAX_SIDES,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // centre_x, centre_y, radius, sides, start_degrees, end_degrees, pad
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // seg_x_begin, seg_y_begin, seg_x_end, seg_y_end, pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    q_stat_t q_stat;
    arc_t push_arc, head;
    logic push, pop;

    apsg_front #(
        .MAX_SIDES (MAX_SIDES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata[75:0]),
        .q_stat   (q_stat),
        .push     (push),
        .push_arc (push_arc)
    );

    apsg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_arc (push_arc),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    apsg_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // never write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue overflow");

    // never read an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue underflow");

    // the front is busy right after taking a request
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front took two requests back to back");

endmodule

// File: tb/arc_polygon_segment_generator_top_test.sv
module arc_polygon_segment_generator_top_test;
    import apsg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        r;
        logic [6:0]         n;
        logic signed [10:0] a0;
        logic signed [10:0] a1;
    } arc_req_t;

    typedef struct packed {
        logic [16:0] xb;
        logic [16:0] yb;
        logic [16:0] xe;
        logic [16:0] ye;
        logic        last;
    } seg_t;

    localparam int CYCLE_LIMIT = 6000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    arc_req_t pending_arcs[$];
    seg_t     expected_segs[$];
    int       mismatches;
    int       cycles;
    bit       stim_done;
    bit       req_taken;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    int       stall_phase;
    int       seg_count;

    arc_polygon_segment_generator_top dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int deg_to_turn_units(longint deg);
        return int'((((deg + 1080) * 16384 + 45) / 90) - 196608);
    endfunction

    // rotation-mode cordic, cos and sin in q1.30
    task automatic rotate_unit(input int ang, output longint c, output longint s);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a = 32'(ang) << 16;
        flip = (a - 32'h40000000) < 32'h80000000;
        if (flip)
            a = a - 32'h80000000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < DEF_CORDIC_STAGES; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_lut(5'(i)));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_lut(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic place_vertex(input int ang, input arc_req_t q,
                                output logic [16:0] vx, output logic [16:0] vy);
        longint c;
        longint s;
        longint rr;
        rotate_unit(ang, c, s);
        rr = longint'(q.r);
        vx = 17'(longint'(q.cx) + floor_shift(rr * c + (64'sd1 <<< 29), 30));
        vy = 17'(longint'(q.cy) + floor_shift(rr * s + (64'sd1 <<< 29), 30));
    endtask

    // segments of one arc
    task automatic predict_segments(input arc_req_t q);
        int     n;
        int     first;
        int     stop;
        int     a2;
        seg_t   sg;
        logic [16:0] bx;
        logic [16:0] by;
        n = int'(q.n);
        if (n < 1)
            n = 1;
        if (n > DEF_MAX_SIDES)
            n = DEF_MAX_SIDES;
        first = deg_to_turn_units(longint'(q.a0));
        stop = deg_to_turn_units(longint'(q.a1));
        place_vertex(first, q, bx, by);
        for (int k = 0; k < n; k++)
        begin
            a2 = first + int'((longint'(k + 1) * 131072 + n) / (2 * n));
            sg.xb = bx;
            sg.yb = by;
            place_vertex(a2, q, sg.xe, sg.ye);
            sg.last = (a2 >= stop) || (k + 1 == n);
            expected_segs.push_back(sg);
            if (sg.last)
                break;
            bx = sg.xe;
            by = sg.ye;
        end
    endtask

    function automatic arc_req_t make_arc(int cx, int cy, int r, int n, int a0, int a1);
        arc_req_t q;
        q.cx = 16'(cx);
        q.cy = 16'(cy);
        q.r = 15'(r);
        q.n = 7'(n);
        q.a0 = 11'(a0);
        q.a1 = 11'(a1);
        return q;
    endfunction

    // stimulus
    initial
    begin
        arc_req_t q;
        int       span;
        pending_arcs.push_back(make_arc(0, 0, 4096, 4, 0, 360));
        pending_arcs.push_back(make_arc(32767, 32767, 32767, 64, -720, 720));
        pending_arcs.push_back(make_arc(-32768, -32768, 32767, 1, 720, -720));
        pending_arcs.push_back(make_arc(100, -100, 0, 8, 0, 90));
        pending_arcs.push_back(make_arc(0, 0, 32767, 0, 0, 10));
        pending_arcs.push_back(make_arc(0, 0, 20000, 127, 0, 30));
        pending_arcs.push_back(make_arc(0, 0, 20000, 100, 45, 45));
        pending_arcs.push_back(make_arc(5, 5, 12345, 6, 90, 270));
        pending_arcs.push_back(make_arc(-5, 7, 16384, 3, 180, 170));
        pending_arcs.push_back(make_arc(0, 0, 32767, 2, -90, 720));
        pending_arcs.push_back(make_arc(32767, -32768, 32767, 5, 270, 719));
        pending_arcs.push_back(make_arc(0, 0, 1, 12, 1, 359));
        pending_arcs.push_back(make_arc(-1, 1, 16383, 64, 0, 1));
        pending_arcs.push_back(make_arc(0, 0, 32767, 7, -720, -700));
        for (int i = 0; i < 456; i++)
        begin
            q.cx = 16'($urandom);
            q.cy = 16'($urandom);
            q.r = 15'($urandom);
            q.n = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16));
            q.a0 = 11'($urandom_range(0, 1440) - 720);
            span = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1440) : $urandom_range(0, 120);
            q.a1 = 11'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1440) - 720
                                                 : (q.a0 + span > 720 ? 720 : q.a0 + span));
            pending_arcs.push_back(q);
        end
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && expected_segs.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_segs.size() == 0)
            $display("** arc_polygon_segment_generator_top: PASSED **");
        else
            $display("** arc_polygon_segment_generator_top: FAILED **");
        $finish;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** arc_polygon_segment_generator_top: FAILED **");
            $finish;
        end
    end

    // request handshake seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= s_axis_tvalid && s_axis_tready;
    end

    // request driver, bursts with gaps
    always @(negedge clk or negedge rst_n)
    begin
        arc_req_t q;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
            stim_done <= 1'b0;
        end
        else if (!s_axis_tvalid || req_taken)
        begin
            if (req_taken)
                predict_segments(pending_arcs.pop_front());
            if (pending_arcs.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                q = pending_arcs[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'd0, q.a1, q.a0, q.n, q.r, q.cy, q.cx};
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 80);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stalls, with one long hold-off early on
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 3000;
            stall_phase <= 0;
        end
        else if (seg_count > 20 && hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9])
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
        end
    end

    // segment monitor
    always @(posedge clk or negedge rst_n)
    begin
        seg_t want;
        seg_t got;
        if (!rst_n)
        begin
            mismatches <= 0;
            seg_count <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            seg_count <= seg_count + 1;
            got.xb = m_axis_tdata[16:0];
            got.yb = m_axis_tdata[33:17];
            got.xe = m_axis_tdata[50:34];
            got.ye = m_axis_tdata[67:51];
            got.last = m_axis_tlast;
            if (expected_segs.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected segment %h last %b", m_axis_tdata, m_axis_tlast);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_segs.pop_front();
                if (want != got)
                begin
                    if (mismatches < 10)
                        $display("segment mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                                 want.xb, want.yb, want.xe, want.ye, want.last,
                                 got.xb, got.yb, got.xe, got.ye, got.last);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end
endmodule
